// ===== sv/ssa_pkg.sv =====
// Shared types and constants of the swap slot allocator.
`timescale 1ns / 1ps
package ssa_pkg;
    localparam int NUM_DEVICES      = 4;
    localparam int SLOTS_PER_DEVICE = 65536;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_DUP   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_NOTUSE  = 2'd3;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 16;
    localparam int DEV_W    = 2;
    localparam int TOTAL_W  = 18;
    localparam int PRIO_W   = 15;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_DUP   = 2'd2;
    localparam logic [1:0] CMD_FAIL  = 2'd3;

    // Classified command passed from the front end to the executing back end.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [STATUS_W-1:0] fail_status;
        logic [DEV_W-1:0]  dev;
        logic [SLOT_W-1:0] slot;
    } t_cmd;
endpackage

// ===== sv/ssa_front.sv =====
// Front end: checks and classifies items, picks the allocation device.
`timescale 1ns / 1ps
module ssa_front #(
    parameter int NUM_DEVICES = 4,
    parameter int SLOTS_PER_DEVICE = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ssa_pkg::MODE_W-1:0]  i_mode,
    input  logic [ssa_pkg::DEV_W-1:0]   i_device,
    input  logic [ssa_pkg::SLOT_W-1:0]  i_slot,
    input  logic [NUM_DEVICES-1:0]      i_enable,
    input  logic [NUM_DEVICES*ssa_pkg::PRIO_W-1:0] i_prio,
    input  logic [NUM_DEVICES-1:0]      i_full,
    input  logic                        i_busy,
    output logic                        o_valid,
    output ssa_pkg::t_cmd               o_cmd
);
    localparam int TOP = SLOTS_PER_DEVICE - 1;

    logic          r_valid;
    ssa_pkg::t_cmd r_cmd;
    ssa_pkg::t_cmd n_cmd;
    logic          v_found;
    logic [ssa_pkg::DEV_W-1:0] v_best;
    logic [ssa_pkg::PRIO_W-1:0] v_bprio;
    logic          v_dev_ok;

    // One item at a time: the back end's busy flag holds new beats off too.
    assign o_stall = r_valid | i_busy;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        v_found = 1'b0;
        v_best  = '0;
        v_bprio = '0;
        for (int d = 0; d < NUM_DEVICES; d++) begin
            if (i_enable[d] && !i_full[d] &&
                (!v_found || i_prio[d*ssa_pkg::PRIO_W +: ssa_pkg::PRIO_W] > v_bprio)) begin
                v_found = 1'b1;
                v_best  = ssa_pkg::DEV_W'(d);
                v_bprio = i_prio[d*ssa_pkg::PRIO_W +: ssa_pkg::PRIO_W];
            end
        end
        v_dev_ok = (32'(i_device) < NUM_DEVICES) && i_enable[i_device];
        n_cmd = '{cmd: ssa_pkg::CMD_FAIL, fail_status: ssa_pkg::ST_INVALID,
                  dev: i_device, slot: i_slot};
        case (i_mode)
            ssa_pkg::MODE_ALLOC: begin
                if (v_found) begin
                    n_cmd.cmd = ssa_pkg::CMD_ALLOC;
                    n_cmd.dev = v_best;
                end else begin
                    n_cmd.fail_status = ssa_pkg::ST_NOFREE;
                end
            end
            ssa_pkg::MODE_FREE, ssa_pkg::MODE_DUP: begin
                if (v_dev_ok && i_slot != '0 && 32'(i_slot) <= TOP)
                    n_cmd.cmd = (i_mode == ssa_pkg::MODE_FREE) ? ssa_pkg::CMD_FREE
                                                               : ssa_pkg::CMD_DUP;
            end
            default: n_cmd.cmd = ssa_pkg::CMD_FAIL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else begin
            r_valid <= 1'b0;
        end
        if (i_valid && !o_stall) r_cmd <= n_cmd;
    end
endmodule

// ===== sv/ssa_back.sv =====
// Back end: count map, next-fit scan, in-use counts and free total.
`timescale 1ns / 1ps
module ssa_back #(
    parameter int NUM_DEVICES = 4,
    parameter int SLOTS_PER_DEVICE = 65536,
    parameter int MAX_REFS = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  ssa_pkg::t_cmd               i_cmd,
    input  logic [NUM_DEVICES-1:0]      i_enable,
    output logic [NUM_DEVICES-1:0]      o_full,
    output logic                        o_busy,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ssa_pkg::STATUS_W-1:0] o_status,
    output logic [ssa_pkg::DEV_W-1:0]   o_result_device,
    output logic [ssa_pkg::SLOT_W-1:0]  o_result_slot,
    output logic [ssa_pkg::TOTAL_W-1:0] o_free_total
);
    localparam int SW    = $clog2(SLOTS_PER_DEVICE);
    localparam int DW    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int AW    = SW + DW;
    localparam int DEPTH = NUM_DEVICES * SLOTS_PER_DEVICE;
    localparam int CW    = (MAX_REFS > 1) ? $clog2(MAX_REFS + 1) : 1;
    localparam int UW    = SW;
    localparam logic [SW-1:0] TOP = SW'(SLOTS_PER_DEVICE - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [CW-1:0] r_map [DEPTH];
    logic [CW-1:0] r_rdata;

    logic [2:0]    r_state;
    logic [AW:0]   r_clr;
    ssa_pkg::t_cmd r_cmd;
    logic [SW-1:0] r_off;
    logic [SW-1:0] r_ptr [NUM_DEVICES];
    logic [UW-1:0] r_use [NUM_DEVICES];
    logic [ssa_pkg::STATUS_W-1:0] r_status;
    logic [ssa_pkg::DEV_W-1:0]    r_rdev;
    logic [ssa_pkg::SLOT_W-1:0]   r_rslot;
    logic [ssa_pkg::TOTAL_W-1:0]  n_total;

    logic          v_we;
    logic [AW-1:0] v_waddr;
    logic [CW-1:0] v_wdata;
    logic [AW-1:0] v_raddr;
    logic [DW-1:0] v_dev;
    logic [SW-1:0] v_next;

    assign v_dev  = DW'(r_cmd.dev);
    assign v_next = (r_off == TOP) ? SW'(1) : r_off + SW'(1);
    assign o_busy = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_result_device = r_rdev;
    assign o_result_slot = r_rslot;
    // in-use counts settle at the end of execution and hold while the result waits
    assign o_free_total = n_total;

    always_comb begin
        for (int d = 0; d < NUM_DEVICES; d++) o_full[d] = (r_use[d] >= TOP);
        n_total = '0;
        for (int d = 0; d < NUM_DEVICES; d++)
            if (i_enable[d] && r_use[d] < TOP)
                n_total = n_total + ssa_pkg::TOTAL_W'(TOP - r_use[d]);
    end

    assign v_raddr = {v_dev, r_off};
    always_comb begin
        v_we = 1'b0;
        v_waddr = v_raddr;
        v_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                v_we = 1'b1;
                v_waddr = r_clr[AW-1:0];
            end
            S_EXEC: begin
                case (r_cmd.cmd)
                    ssa_pkg::CMD_ALLOC: begin
                        v_we = (r_rdata == '0);
                        v_wdata = CW'(1);
                    end
                    ssa_pkg::CMD_FREE: begin
                        v_we = (r_rdata != '0);
                        v_wdata = r_rdata - CW'(1);
                    end
                    ssa_pkg::CMD_DUP: begin
                        v_we = (r_rdata != '0) && (32'(r_rdata) < MAX_REFS);
                        v_wdata = r_rdata + CW'(1);
                    end
                    default: v_we = 1'b0;
                endcase
            end
            default: v_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_map[v_waddr] <= v_wdata;
        r_rdata <= r_map[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            for (int d = 0; d < NUM_DEVICES; d++) begin
                r_ptr[d] <= SW'(1);
                r_use[d] <= '0;
            end
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == DEPTH - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_rdev <= '0;
                        r_rslot <= '0;
                        if (i_cmd.cmd == ssa_pkg::CMD_FAIL) begin
                            r_status <= i_cmd.fail_status;
                            r_state <= S_OUT;
                        end else begin
                            r_off <= (i_cmd.cmd == ssa_pkg::CMD_ALLOC) ?
                                     r_ptr[DW'(i_cmd.dev)] : SW'(i_cmd.slot);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    case (r_cmd.cmd)
                        ssa_pkg::CMD_ALLOC: begin
                            if (r_rdata == '0) begin
                                r_ptr[v_dev] <= v_next;
                                r_use[v_dev] <= r_use[v_dev] + 1'b1;
                                r_status <= ssa_pkg::ST_OK;
                                r_rdev <= r_cmd.dev;
                                r_rslot <= ssa_pkg::SLOT_W'(r_off);
                                r_state <= S_OUT;
                            end else begin
                                // advance the scan one slot, wrapping past slot 0
                                r_off <= v_next;
                                r_state <= S_READ;
                            end
                        end
                        ssa_pkg::CMD_FREE: begin
                            if (r_rdata != '0) begin
                                r_status <= ssa_pkg::ST_OK;
                                if (r_rdata == CW'(1) && r_use[v_dev] != '0)
                                    r_use[v_dev] <= r_use[v_dev] - 1'b1;
                            end else begin
                                r_status <= ssa_pkg::ST_NOTUSE;
                            end
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_status <= v_we ? ssa_pkg::ST_OK : ssa_pkg::ST_NOTUSE;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a granted slot is never the reserved slot 0
    a_slot_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ssa_pkg::ST_OK && r_cmd.cmd == ssa_pkg::CMD_ALLOC)
        |-> o_result_slot != '0) else $error("slot 0 granted");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ssa_pkg::ST_OK) |-> o_result_slot == '0)
        else $error("failure with slot");
endmodule

// ===== sv/swap_slot_allocator_unit.sv =====
// Top level of the swap slot allocator: register file, front end and back end.
//   channel | direction | handshake          | payload
//   in      | in        | i_valid / o_stall  | mode, device, slot
//   out     | out       | o_valid / i_stall  | status, result_device, result_slot, free_total
//   cfg     | in        | APB                | enable, prio0..3
// Free and duplicate: the item is registered in the front end, then passes the back end's
// read, exec and out states; a new beat is taken only after the last result has left.
// Allocate: the next-fit scan repeats read and exec for each map slot it reads through the
// single map port. Rejected items go from idle straight to out. After reset the map is
// cleared one entry a cycle, all NUM_DEVICES*SLOTS_PER_DEVICE entries (262144 by default), before items are taken.
// A stalled result holds in the back end's output registers and in-use counts.
`timescale 1ns / 1ps
module swap_slot_allocator_unit #(
    parameter int MAX_REFS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_device,
    input  logic [15:0] i_slot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_result_device,
    output logic [15:0] o_result_slot,
    output logic [17:0] o_free_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NUM_DEVICES = ssa_pkg::NUM_DEVICES;
    localparam int SLOTS_PER_DEVICE = ssa_pkg::SLOTS_PER_DEVICE;
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_PRIO0  = 3'd1;
    localparam logic [2:0] REG_PRIO3  = 3'd4;
    localparam int PW = ssa_pkg::PRIO_W;

    logic [3:0]  r_enable;
    logic [PW-1:0] r_prio [4];
    logic [NUM_DEVICES-1:0] v_en;
    logic [NUM_DEVICES*PW-1:0] v_prio;
    logic [NUM_DEVICES-1:0] v_full;
    logic        v_busy;
    logic        v_cvalid;
    ssa_pkg::t_cmd v_cmd;
    logic [2:0]  v_idx;

    assign pready = 1'b1;
    assign v_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            for (int k = 0; k < 4; k++) r_prio[k] <= '0;
        end else if (psel && penable && pwrite) begin
            if (v_idx == REG_ENABLE) r_enable <= pwdata[3:0];
            else if (v_idx <= REG_PRIO3) r_prio[2'(v_idx - REG_PRIO0)] <= pwdata[PW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (v_idx == REG_ENABLE) prdata = {28'd0, r_enable};
        else if (v_idx <= REG_PRIO3) prdata = {17'd0, r_prio[2'(v_idx - REG_PRIO0)]};
        for (int d = 0; d < NUM_DEVICES; d++) begin
            v_en[d] = (d < 4) ? r_enable[d % 4] : 1'b0;
            v_prio[d*PW +: PW] = (d < 4) ? r_prio[d % 4] : '0;
        end
    end

    ssa_front #(.NUM_DEVICES(NUM_DEVICES), .SLOTS_PER_DEVICE(SLOTS_PER_DEVICE)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_device, .i_slot,
        .i_enable(v_en), .i_prio(v_prio), .i_full(v_full), .i_busy(v_busy),
        .o_valid(v_cvalid), .o_cmd(v_cmd)
    );

    ssa_back #(.NUM_DEVICES(NUM_DEVICES), .SLOTS_PER_DEVICE(SLOTS_PER_DEVICE),
               .MAX_REFS(MAX_REFS)) u_back (
        .i_clk, .i_rst_n, .i_valid(v_cvalid), .i_cmd(v_cmd), .i_enable(v_en),
        .o_full(v_full), .o_busy(v_busy), .o_valid, .i_stall, .o_status,
        .o_result_device, .o_result_slot, .o_free_total
    );
endmodule
